// ----- sv/mcc_pkg.sv -----
package mcc_pkg;

	// table and coin set sizes
	localparam int MAX_AMOUNT     = 1024;
	localparam int MAX_COINS      = 6;
	localparam int NUM_VALUE_REGS = 6;
	localparam int COIN_LIMIT     = (MAX_COINS < NUM_VALUE_REGS) ? MAX_COINS : NUM_VALUE_REGS;

	// field widths
	localparam int AMT_W      = 10;
	localparam int CNT_W      = 10;
	localparam int ENTRY_W    = CNT_W + 1;
	localparam int ADDR_W     = $clog2(MAX_AMOUNT);
	localparam int COIN_IDX_W = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_L = CFG_IDX_W'(NUM_VALUE_REGS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_SCAN,
		ST_STORE,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic seed;
		logic scan;
		logic store;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic trivial;
		logic last_coin;
		logic sum_done;
	} sts_t;

endpackage

// ----- sv/mcc_if.sv -----
interface mcc_req_if;
	import mcc_pkg::*;
	logic             valid;
	logic             ready;
	logic [AMT_W-1:0] amount;
	modport source (output valid, output amount, input ready);
	modport sink   (input valid, input amount, output ready);
endinterface

interface mcc_rsp_if;
	import mcc_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] min_coins;
	logic             unreachable;
	modport source (output valid, output min_coins, output unreachable, input ready);
	modport sink   (input valid, input min_coins, input unreachable, output ready);
endinterface

interface mcc_cfg_if;
	import mcc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mcc_ram.sv -----
module mcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/mcc_datapath.sv -----
module mcc_datapath import mcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [AMT_W-1:0]      amount,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [CNT_W-1:0]      min_coins,
	output logic                  unreachable
);

	logic [2:0]            coin_count_q;
	logic [AMT_W-1:0]      coin_val_q [NUM_VALUE_REGS];
	logic [AMT_W-1:0]      amount_q;
	logic [AMT_W-1:0]      sum_q;
	logic [COIN_IDX_W-1:0] coin_idx_q;
	logic                  rd_s1;
	logic                  found_q;
	logic [CNT_W-1:0]      best_q;
	logic [CNT_W-1:0]      res_cnt_q;
	logic                  res_unr_q;
	logic [CNT_W-1:0]      out_cnt_q;
	logic                  out_unr_q;

	logic [COIN_IDX_W-1:0] n_active;
	logic [AMT_W-1:0]      coin;
	logic                  coin_ok;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ENTRY_W-1:0]    rd_data;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ENTRY_W-1:0]    wr_data;
	logic                  cand_ok;
	logic [CNT_W-1:0]      cand;
	logic                  new_found;
	logic [CNT_W-1:0]      new_best;
	logic                  out_of_range;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_count_q <= 3'd1;
			for (int i = 0; i < NUM_VALUE_REGS; i++) begin
				coin_val_q[i] <= AMT_W'(1);
			end
		end else if (cfg_wr) begin
			if (cfg_index == REG_COIN_COUNT) begin
				coin_count_q <= cfg_data[2:0];
			end else if (cfg_index >= REG_COIN_VALUE_0 && cfg_index <= REG_COIN_VALUE_L) begin
				coin_val_q[COIN_IDX_W'(cfg_index - REG_COIN_VALUE_0)] <= cfg_data[AMT_W-1:0];
			end
		end
	end

	// active coin count, saturated to the register set
	assign n_active = (coin_count_q > 3'(COIN_LIMIT)) ? COIN_IDX_W'(COIN_LIMIT)
	                                                  : COIN_IDX_W'(coin_count_q);

	// current coin and remainder read
	assign coin    = coin_val_q[coin_idx_q];
	assign coin_ok = (coin_idx_q < n_active) && (coin != '0) && (coin <= sum_q);
	assign rd_en   = cmd.scan && coin_ok;
	assign rd_addr = ADDR_W'(sum_q - coin);

	// fold the returned entry into the running minimum
	assign cand_ok   = rd_s1 && rd_data[CNT_W];
	assign cand      = (rd_data[CNT_W-1:0] == CNT_MAX) ? CNT_MAX : rd_data[CNT_W-1:0] + 1'b1;
	assign new_found = found_q || cand_ok;
	assign new_best  = (cand_ok && (!found_q || cand < best_q)) ? cand : best_q;

	// table write: seed entry zero, or store the finished sum
	assign wr_en   = cmd.seed || cmd.store;
	assign wr_addr = cmd.seed ? '0 : ADDR_W'(sum_q);
	assign wr_data = cmd.seed ? {1'b1, {CNT_W{1'b0}}}
	                          : {new_found, (new_found ? new_best : {CNT_W{1'b0}})};

	mcc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_AMOUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_of_range = (32'(amount) >= 32'(MAX_AMOUNT));

	// control state of the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1      <= 1'b0;
			found_q    <= 1'b0;
			coin_idx_q <= '0;
		end else begin
			rd_s1 <= rd_en;
			if (cmd.load || cmd.store) begin
				coin_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (cmd.scan) begin
				coin_idx_q <= coin_idx_q + 1'b1;
				found_q    <= new_found;
			end
		end
	end

	// sum, amount, running best and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			amount_q  <= amount;
			sum_q     <= AMT_W'(1);
			res_cnt_q <= '0;
			res_unr_q <= out_of_range;
		end else if (cmd.store) begin
			sum_q <= sum_q + 1'b1;
			if (sum_q == amount_q) begin
				res_cnt_q <= new_found ? new_best : '0;
				res_unr_q <= !new_found;
			end
		end
		if (cmd.scan) begin
			best_q <= new_best;
		end
		if (cmd.load_out) begin
			out_cnt_q <= res_cnt_q;
			out_unr_q <= res_unr_q;
		end
	end

	assign sts.trivial   = (amount == '0) || out_of_range;
	assign sts.last_coin = (n_active == '0) || (coin_idx_q == n_active - 1'b1);
	assign sts.sum_done  = (sum_q == amount_q);

	assign min_coins   = out_cnt_q;
	assign unreachable = out_unr_q;

	// a read only ever looks at a sum below the one in progress
	a_rd_below_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_addr < ADDR_W'(sum_q)))
		else $error("table read at or above current sum");

	// never read and write the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("table read and write collide");

	// an unreachable result always carries a zero count
	a_unr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (!out_unr_q || out_cnt_q == '0))
		else $error("unreachable result with nonzero count");

endmodule

// ----- sv/mcc_ctrl.sv -----
module mcc_ctrl import mcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_vld_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.trivial ? ST_DONE : ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last_coin) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = sts.sum_done ? ST_DONE : ST_SCAN;
			end
			ST_DONE: begin
				if (!out_vld_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign rsp_valid = out_vld_q;

	// an accepted transaction always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != ST_IDLE))
		else $error("accepted transaction did not start");

	// a store is always preceded by a scan cycle
	a_store_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE) |-> ($past(state_q) == ST_SCAN))
		else $error("store without a scan");

	// the scan always begins with the seed of entry zero
	a_seed_then_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED) |=> (state_q == ST_SCAN))
		else $error("seed not followed by scan");

endmodule

// ----- sv/min_coin_change_dp.sv -----
// minimum coin change by bottom-up dynamic programming
//
// req carries one amount per transaction; rsp returns min_coins and
// unreachable for it. cfg writes registers: index 0 is the number of
// coins in use, indexes 1 to 6 the coin values; cfg is always ready, but
// the user must write it only while the block is idle; it is not checked.
// for each sum from 1 to the amount the sequencer walks the active coins,
// one table read per cycle from the single read port of the table RAM,
// then writes the entry for that sum back in the store state.
// amount zero or beyond the table skips the scan and goes straight to
// done. one amount is worked at a time: the next is taken only after a
// result is loaded into the output register.
// reset returns to idle with one coin of value 1; the table needs no
// clearing since every entry is written before it is read.
// a result waits in an output register while rsp is stalled; the next
// amount may be taken meanwhile, and its result is held until the
// output register frees up.
module min_coin_change_dp import mcc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	mcc_req_if.sink   req,
	mcc_rsp_if.source rsp,
	mcc_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	mcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mcc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.amount      (req.amount),
		.cfg_wr      (cfg.valid && cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.min_coins   (rsp.min_coins),
		.unreachable (rsp.unreachable)
	);

endmodule
